// ----- rtl/tun_pkg.sv -----
package tun_pkg;

   // default coordinate width and normal fraction bits
   localparam int TUN_COORD_WIDTH = 16;
   localparam int TUN_FRAC_BITS   = 14;

   // fixed width of every coordinate and normal field
   localparam int TUN_FIELD_WIDTH = 16;

   // number of vertex coordinates in one triangle
   localparam int TUN_NUM_COORDS  = 9;

endpackage

// ----- rtl/triangle_unit_normal_top.sv -----
// triangle unit normal, streaming
//
// The req_ channel takes one triangle per beat: three vertices p0, p1, p2
// with signed coordinates. The rsp_ channel returns one beat per triangle:
// the face normal (p1-p0) x (p2-p0) scaled to unit length, each component
// in signed Q1.NORMAL_FRAC_BITS, rounded to nearest with ties away from
// zero, and a degenerate flag with all-zero components when the cross
// product is zero.
//
// Throughput is one triangle per cycle while rsp_ready is high: six
// stages form edges, cross product and squared length, then one stage
// per result bit decides the rounded quotient by shift-and-add updates of
// t^2*s and t*s, and a final output register holds the response.
//
// Every stage has its own valid bit and loads whenever it is empty or its
// successor moves, so a stalled receiver only freezes the occupied stages
// at the end; bubbles are squeezed out and nothing is lost or repeated.
// Reset clears all valid bits; data registers are not reset.
module triangle_unit_normal_top import tun_pkg::*; #(
   parameter int COORD_WIDTH      = TUN_COORD_WIDTH,
   parameter int NORMAL_FRAC_BITS = TUN_FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [TUN_FIELD_WIDTH-1:0] req_p0_x,
   input  logic signed [TUN_FIELD_WIDTH-1:0] req_p0_y,
   input  logic signed [TUN_FIELD_WIDTH-1:0] req_p0_z,
   input  logic signed [TUN_FIELD_WIDTH-1:0] req_p1_x,
   input  logic signed [TUN_FIELD_WIDTH-1:0] req_p1_y,
   input  logic signed [TUN_FIELD_WIDTH-1:0] req_p1_z,
   input  logic signed [TUN_FIELD_WIDTH-1:0] req_p2_x,
   input  logic signed [TUN_FIELD_WIDTH-1:0] req_p2_y,
   input  logic signed [TUN_FIELD_WIDTH-1:0] req_p2_z,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [TUN_FIELD_WIDTH-1:0] rsp_normal_x,
   output logic signed [TUN_FIELD_WIDTH-1:0] rsp_normal_y,
   output logic signed [TUN_FIELD_WIDTH-1:0] rsp_normal_z,
   output logic                              rsp_degenerate
);

   localparam int W   = COORD_WIDTH;
   localparam int F   = NORMAL_FRAC_BITS;
   localparam int XW  = (W > TUN_FIELD_WIDTH) ? W : TUN_FIELD_WIDTH;
   localparam int E   = W + 1;             // edge width
   localparam int H   = W + 1;             // half of the magnitude
   localparam int M   = 2 * H;             // cross magnitude width
   localparam int CW  = 2 * W + 3;         // signed cross width
   localparam int C2W = 2 * M;             // squared component width
   localparam int SW  = 2 * M + 2;         // squared length width
   localparam int RW  = 2 * M + 2 * F + 2; // comparison bound width
   localparam int PW  = 2 * M + 2 * F + 7; // t^2*s and t*s width
   localparam int QW  = F + 1;             // quotient magnitude width
   localparam int NW  = F + 2;             // signed quotient width
   localparam int OW  = (NW > TUN_FIELD_WIDTH) ? NW : TUN_FIELD_WIDTH;
   localparam int NS  = F + 8;             // pipeline stages
   localparam int SB  = 5;                 // stage index of search setup

   // stage control
   logic [NS-1:0] vld_ff;
   logic [NS:0]   en;

   assign en[NS] = rsp_ready;
   for (genvar i = 0; i < NS; i++) begin : g_en
      assign en[i] = !vld_ff[i] || en[i+1];
   end

   assign req_ready = en[0];
   assign rsp_valid = vld_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int i = 1; i < NS; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   // coordinate fields, low bits sign extended
   logic [TUN_FIELD_WIDTH-1:0] fld [TUN_NUM_COORDS];
   logic [XW-1:0]              raw_ext [TUN_NUM_COORDS];
   logic signed [W-1:0]        crd [TUN_NUM_COORDS];

   assign fld[0] = req_p0_x;
   assign fld[1] = req_p0_y;
   assign fld[2] = req_p0_z;
   assign fld[3] = req_p1_x;
   assign fld[4] = req_p1_y;
   assign fld[5] = req_p1_z;
   assign fld[6] = req_p2_x;
   assign fld[7] = req_p2_y;
   assign fld[8] = req_p2_z;

   for (genvar i = 0; i < TUN_NUM_COORDS; i++) begin : g_crd
      assign raw_ext[i] = XW'(fld[i]);
      assign crd[i]     = signed'(raw_ext[i][W-1:0]);
   end

   // stage 0: edges
   logic signed [E-1:0] ea_ff [3];
   logic signed [E-1:0] eb_ff [3];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int i = 0; i < 3; i++) begin
            ea_ff[i] <= E'(crd[3+i]) - E'(crd[i]);
            eb_ff[i] <= E'(crd[6+i]) - E'(crd[i]);
         end
      end
   end

   // stage 1: cross product terms
   logic signed [2*E-1:0] pr_ff [6];

   always_ff @(posedge clock) begin
      if (en[1]) begin
         pr_ff[0] <= (2*E)'(ea_ff[1]) * (2*E)'(eb_ff[2]);
         pr_ff[1] <= (2*E)'(ea_ff[2]) * (2*E)'(eb_ff[1]);
         pr_ff[2] <= (2*E)'(ea_ff[2]) * (2*E)'(eb_ff[0]);
         pr_ff[3] <= (2*E)'(ea_ff[0]) * (2*E)'(eb_ff[2]);
         pr_ff[4] <= (2*E)'(ea_ff[0]) * (2*E)'(eb_ff[1]);
         pr_ff[5] <= (2*E)'(ea_ff[1]) * (2*E)'(eb_ff[0]);
      end
   end

   // stage 2: cross product, split into sign and magnitude
   logic signed [CW-1:0] cr_in [3];
   logic [CW-1:0]        cabs [3];
   logic [M-1:0]         cm_ff [3];
   logic [2:0]           cs_in;

   for (genvar i = 0; i < 3; i++) begin : g_cross
      assign cr_in[i] = CW'(pr_ff[2*i]) - CW'(pr_ff[2*i+1]);
      assign cs_in[i] = cr_in[i][CW-1];
      assign cabs[i]  = cs_in[i] ? CW'(-cr_in[i]) : CW'(cr_in[i]);
   end

   logic [2:0] sg2_ff, sg3_ff, sg4_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         for (int i = 0; i < 3; i++) begin
            cm_ff[i] <= cabs[i][M-1:0];
         end
         sg2_ff <= cs_in;
      end
   end

   // stage 3: partial products of the squared magnitude
   logic [2*H-1:0] hh_ff [3];
   logic [2*H-1:0] hl_ff [3];
   logic [2*H-1:0] ll_ff [3];

   always_ff @(posedge clock) begin
      if (en[3]) begin
         for (int i = 0; i < 3; i++) begin
            hh_ff[i] <= (2*H)'(cm_ff[i][M-1:H]) * (2*H)'(cm_ff[i][M-1:H]);
            hl_ff[i] <= (2*H)'(cm_ff[i][M-1:H]) * (2*H)'(cm_ff[i][H-1:0]);
            ll_ff[i] <= (2*H)'(cm_ff[i][H-1:0]) * (2*H)'(cm_ff[i][H-1:0]);
         end
         sg3_ff <= sg2_ff;
      end
   end

   // stage 4: squared components
   logic [C2W-1:0] c2_ff [3];

   always_ff @(posedge clock) begin
      if (en[4]) begin
         for (int i = 0; i < 3; i++) begin
            c2_ff[i] <= (C2W'(hh_ff[i]) << (2*H)) + (C2W'(hl_ff[i]) << (H+1))
                      + C2W'(ll_ff[i]);
         end
         sg4_ff <= sg3_ff;
      end
   end

   // stage 5: squared length, bounds and search start (q = 0, t = -1)
   logic [SW-1:0]        s_in;
   logic [SW-1:0]        sv_ff  [0:F+1];
   logic [RW-1:0]        rhs_ff [0:F+1][3];
   logic signed [PW-1:0] pp_ff  [0:F+1][3];
   logic signed [PW-1:0] qq_ff  [0:F+1][3];
   logic [QW-1:0]        qv_ff  [0:F+1][3];
   logic                 dg_ff  [0:F+1];
   logic [2:0]           sgs_ff [0:F+1];

   assign s_in = SW'(c2_ff[0]) + SW'(c2_ff[1]) + SW'(c2_ff[2]);

   always_ff @(posedge clock) begin
      if (en[SB]) begin
         sv_ff[0]  <= s_in;
         dg_ff[0]  <= (s_in == '0);
         sgs_ff[0] <= sg4_ff;
         for (int i = 0; i < 3; i++) begin
            rhs_ff[0][i] <= RW'(c2_ff[i]) << (2*F + 2);
            pp_ff[0][i]  <= signed'(PW'(s_in));
            qq_ff[0][i]  <= -signed'(PW'(s_in));
            qv_ff[0][i]  <= '0;
         end
      end
   end

   // search stages: one quotient bit each, msb first
   for (genvar j = 1; j <= F + 1; j++) begin : g_srch
      localparam int K = F + 1 - j;
      logic signed [PW-1:0] s_ext;
      logic signed [PW-1:0] p_try [3];
      logic                 take  [3];

      assign s_ext = signed'(PW'(sv_ff[j-1]));

      for (genvar i = 0; i < 3; i++) begin : g_lane
         assign p_try[i] = pp_ff[j-1][i] + (qq_ff[j-1][i] <<< (K + 2))
                         + (s_ext <<< (2*K + 2));
         assign take[i]  = p_try[i] <= signed'(PW'(rhs_ff[j-1][i]));
      end

      always_ff @(posedge clock) begin
         if (en[SB+j]) begin
            sv_ff[j]  <= sv_ff[j-1];
            dg_ff[j]  <= dg_ff[j-1];
            sgs_ff[j] <= sgs_ff[j-1];
            for (int i = 0; i < 3; i++) begin
               rhs_ff[j][i] <= rhs_ff[j-1][i];
               if (take[i]) begin
                  pp_ff[j][i] <= p_try[i];
                  qq_ff[j][i] <= qq_ff[j-1][i] + (s_ext <<< (K + 1));
                  qv_ff[j][i] <= qv_ff[j-1][i] | (QW'(1) << K);
               end else begin
                  pp_ff[j][i] <= pp_ff[j-1][i];
                  qq_ff[j][i] <= qq_ff[j-1][i];
                  qv_ff[j][i] <= qv_ff[j-1][i];
               end
            end
         end
      end
   end

   // output register: apply sign, clear on degenerate
   logic signed [NW-1:0]              nq [3];
   logic signed [OW-1:0]              nx [3];
   logic signed [TUN_FIELD_WIDTH-1:0] nrm_ff [3];
   logic                              dgo_ff;

   for (genvar i = 0; i < 3; i++) begin : g_out
      assign nq[i] = sgs_ff[F+1][i] ? -signed'(NW'(qv_ff[F+1][i]))
                                    :  signed'(NW'(qv_ff[F+1][i]));
      assign nx[i] = OW'(nq[i]);
   end

   always_ff @(posedge clock) begin
      if (en[NS-1]) begin
         dgo_ff <= dg_ff[F+1];
         for (int i = 0; i < 3; i++) begin
            nrm_ff[i] <= dg_ff[F+1] ? '0 : nx[i][TUN_FIELD_WIDTH-1:0];
         end
      end
   end

   assign rsp_normal_x   = nrm_ff[0];
   assign rsp_normal_y   = nrm_ff[1];
   assign rsp_normal_z   = nrm_ff[2];
   assign rsp_degenerate = dgo_ff;

   // checks
   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0)
      else $error("degenerate beat with nonzero normal");

   a_accept_fill: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted beat not captured in first stage");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NS-1] && !rsp_ready && vld_ff[NS-2] |=> vld_ff[NS-2])
      else $error("stage before output lost a beat under stall");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_normal_x) && $stable(rsp_normal_y)
         && $stable(rsp_normal_z) && $stable(rsp_degenerate))
      else $error("response beat changed while stalled");

endmodule
